// ===== hw/rtl/pfla_pkg.sv =====
// Shared types and constants of the page free-list allocator.
// Used by pfla_core and page_free_list_allocator; depends on nothing else.
package pfla_pkg;

    // Store geometry.
    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int LINK_W    = PAGE_W + 1;
    localparam int PN_W      = 14;

    // Link word codes: a next-free page, the list end or the used mark.
    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(MAX_PAGES);
    localparam logic [LINK_W-1:0] LINK_USED = LINK_W'(MAX_PAGES + 1);

    // Stream beat widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FILE_OPEN = 1'b0;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_DISPOSE  = 3'd1,
        OP_GET_THIS = 3'd2,
        OP_GET_NEXT = 3'd3,
        OP_GET_PREV = 3'd4,
        OP_GET_FRST = 3'd5,
        OP_GET_LAST = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_INVALID = 3'd2,
        ST_FREE    = 3'd3,
        ST_EOF     = 3'd4,
        ST_NOSPACE = 3'd5
    } t_status;

    // One request as it travels from the stream port to the core.
    typedef struct packed {
        t_op              op;
        logic [PN_W-1:0]  page;   // two's complement page number
    } t_cmd;

    // One result as it travels from the core to the output register.
    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] page;
        logic              dirty;
    } t_result;

endpackage

// ===== hw/rtl/pfla_core.sv =====
// Allocator core: link store memory, free-list head, page count and the
// operation sequencer. Depends on pfla_pkg.
module pfla_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_file_open,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  pfla_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output pfla_pkg::t_result o_res
);
    import pfla_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SCAN = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [PN_W-1:0]   r_cur, n_cur;
    logic              r_up, n_up;
    logic              r_pend, n_pend;
    logic [PAGE_W-1:0] r_rd_addr, n_rd_addr;
    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic [LINK_W-1:0] r_page_count, n_page_count;
    logic              r_dirty, n_dirty;
    t_result           r_hold, n_hold;

    // Link store and its ports.
    logic [LINK_W-1:0] mem [MAX_PAGES];
    logic [LINK_W-1:0] r_rdata;
    logic              w_re, w_we;
    logic [PAGE_W-1:0] w_raddr, w_waddr;
    logic [LINK_W-1:0] w_wdata;

    // Completion of an operation in this cycle.
    logic    w_fin;
    t_result w_fin_res;

    logic w_accept, w_pn_valid, w_pn_is_count, w_in_range, w_found;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd_valid && o_cmd_ready;

    // The page number names a page of the file when it is non-negative
    // and below the page count.
    assign w_pn_valid    = !i_cmd.page[PN_W-1] &&
                           (i_cmd.page[PN_W-2:0] < r_page_count);
    assign w_pn_is_count = !i_cmd.page[PN_W-1] &&
                           (i_cmd.page[PN_W-2:0] == r_page_count);

    // Scan cursor bounds and the check of the previous read.
    assign w_in_range = !r_cur[PN_W-1] &&
                        (!r_up || (r_cur[PN_W-2:0] < r_page_count));
    assign w_found    = r_pend && (r_rdata == LINK_USED);

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_page       = r_page;
        n_cur        = r_cur;
        n_up         = r_up;
        n_pend       = r_pend;
        n_rd_addr    = r_rd_addr;
        n_free_head  = r_free_head;
        n_page_count = r_page_count;
        n_dirty      = r_dirty;
        n_hold       = r_hold;
        w_re         = 1'b0;
        w_raddr      = i_cmd.page[PAGE_W-1:0];
        w_we         = 1'b0;
        w_waddr      = r_page;
        w_wdata      = LINK_USED;
        w_fin        = 1'b0;
        w_fin_res    = '{status: ST_OK, page: '0, dirty: r_dirty};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op = i_cmd.op;
                    if (!i_file_open) begin
                        w_fin = 1'b1;
                        w_fin_res.status = ST_CLOSED;
                    end else begin
                        case (i_cmd.op)
                            OP_ALLOC: begin
                                if (!r_free_head[LINK_W-1]) begin
                                    // Pop: fetch the link of the list head.
                                    w_re    = 1'b1;
                                    w_raddr = r_free_head[PAGE_W-1:0];
                                    n_page  = r_free_head[PAGE_W-1:0];
                                    n_state = S_LOOK;
                                end else if (!r_page_count[LINK_W-1]) begin
                                    // Grow the file by one page.
                                    w_we         = 1'b1;
                                    w_waddr      = r_page_count[PAGE_W-1:0];
                                    n_page_count = r_page_count + LINK_W'(1);
                                    n_dirty      = 1'b1;
                                    w_fin        = 1'b1;
                                    w_fin_res.page  = r_page_count[PAGE_W-1:0];
                                    w_fin_res.dirty = 1'b1;
                                end else begin
                                    w_fin = 1'b1;
                                    w_fin_res.status = ST_NOSPACE;
                                end
                            end
                            OP_DISPOSE, OP_GET_THIS: begin
                                if (w_pn_valid) begin
                                    w_re    = 1'b1;
                                    n_page  = i_cmd.page[PAGE_W-1:0];
                                    n_state = S_LOOK;
                                end else begin
                                    w_fin = 1'b1;
                                    w_fin_res.status = ST_INVALID;
                                end
                            end
                            OP_GET_NEXT: begin
                                if (w_pn_valid || (i_cmd.page == '1)) begin
                                    n_cur   = i_cmd.page + PN_W'(1);
                                    n_up    = 1'b1;
                                    n_pend  = 1'b0;
                                    n_state = S_SCAN;
                                end else begin
                                    w_fin = 1'b1;
                                    w_fin_res.status = ST_INVALID;
                                end
                            end
                            OP_GET_PREV: begin
                                if (w_pn_valid || w_pn_is_count) begin
                                    n_cur   = i_cmd.page - PN_W'(1);
                                    n_up    = 1'b0;
                                    n_pend  = 1'b0;
                                    n_state = S_SCAN;
                                end else begin
                                    w_fin = 1'b1;
                                    w_fin_res.status = ST_INVALID;
                                end
                            end
                            OP_GET_FRST: begin
                                n_cur   = '0;
                                n_up    = 1'b1;
                                n_pend  = 1'b0;
                                n_state = S_SCAN;
                            end
                            OP_GET_LAST: begin
                                n_cur   = {1'b0, r_page_count} - PN_W'(1);
                                n_up    = 1'b0;
                                n_pend  = 1'b0;
                                n_state = S_SCAN;
                            end
                            default: begin
                                w_fin = 1'b1;
                                w_fin_res.status = ST_INVALID;
                            end
                        endcase
                    end
                end
            end

            S_LOOK: begin
                w_fin = 1'b1;
                case (r_op)
                    OP_ALLOC: begin
                        // Unlink the head and mark it used.
                        n_free_head     = r_rdata;
                        w_we            = 1'b1;
                        n_dirty         = 1'b1;
                        w_fin_res.page  = r_page;
                        w_fin_res.dirty = 1'b1;
                    end
                    OP_DISPOSE: begin
                        if (r_rdata != LINK_USED) begin
                            w_fin_res.status = ST_FREE;
                        end else begin
                            // Push the page onto the free list.
                            w_we            = 1'b1;
                            w_wdata         = r_free_head;
                            n_free_head     = {1'b0, r_page};
                            n_dirty         = 1'b1;
                            w_fin_res.dirty = 1'b1;
                        end
                    end
                    default: begin
                        if (r_rdata == LINK_USED) begin
                            w_fin_res.page = r_page;
                        end else begin
                            w_fin_res.status = ST_INVALID;
                        end
                    end
                endcase
            end

            S_SCAN: begin
                // One link read per cycle; its check follows in the next cycle.
                if (w_found) begin
                    w_fin          = 1'b1;
                    w_fin_res.page = r_rd_addr;
                end else if (w_in_range) begin
                    w_re      = 1'b1;
                    w_raddr   = r_cur[PAGE_W-1:0];
                    n_rd_addr = r_cur[PAGE_W-1:0];
                    n_pend    = 1'b1;
                    n_cur     = r_up ? (r_cur + PN_W'(1)) : (r_cur - PN_W'(1));
                end else begin
                    w_fin = 1'b1;
                    w_fin_res.status = ST_EOF;
                end
            end

            S_HOLD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // A finished result leaves at once or waits in the hold register.
        if (w_fin) begin
            if (i_res_ready) begin
                n_state = S_IDLE;
            end else begin
                n_hold  = w_fin_res;
                n_state = S_HOLD;
            end
        end
    end

    assign o_res_valid = w_fin || (r_state == S_HOLD);
    assign o_res       = (r_state == S_HOLD) ? r_hold : w_fin_res;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_free_head  <= LINK_END;
            r_page_count <= '0;
            r_dirty      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_free_head  <= n_free_head;
            r_page_count <= n_page_count;
            r_dirty      <= n_dirty;
        end
    end

    // Operation payload.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_page    <= n_page;
        r_cur     <= n_cur;
        r_up      <= n_up;
        r_rd_addr <= n_rd_addr;
        r_hold    <= n_hold;
    end

    // Link store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // The free-list head is a page number or the list end.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_free_head[LINK_W-1] && (r_free_head[PAGE_W-1:0] != '0)))
        else $error("free-list head beyond the list end");

    // The page count never exceeds the store size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_count <= LINK_W'(MAX_PAGES))
        else $error("page count beyond the store size");

    // The page count grows by one or stays.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_page_count == $past(r_page_count)) ||
            (r_page_count == $past(r_page_count) + LINK_W'(1)))
        else $error("page count moved by other than one");

    // The store is never written while a scan walks it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && (r_state == S_SCAN)))
        else $error("link write during a scan");

    // The dirty flag is never cleared once set.
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |=> r_dirty)
        else $error("header dirty flag cleared");

endmodule

// ===== hw/rtl/page_free_list_allocator.sv =====
// Page free-list allocator top level: stream ports, configuration port and
// the output register. Depends on pfla_pkg and pfla_core.
//
// Usage: requests arrive as beats on the s_axis channel (operation and page
// number), one result beat per request leaves on the m_axis channel (status,
// page found or allocated, header dirty flag). The file_open register at
// byte address 0 of the configuration port gates all operations.
//
// Path from request beat to result in the output register:
//   closed, invalid, grow-allocate and no-space outcomes finish as the
//   request is taken; allocate from the free list, dispose and get-this
//   first read one link word; allocate, and dispose of a used page, then
//   write that link word anew. Scans visit the pages one by one, since
//   the single read port of the link store checks one page per cycle.
// One request is in work at a time; the next is taken as soon as the
// previous result has moved into the output register.
// Reset leaves an empty file: no pages, empty free list, header clean and
// file_open cleared. The link store needs no clearing pass.
// When the receiver stalls, the result waits in the output register and a
// second finished result waits inside the core; input is then held off.
module page_free_list_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // s_axis_tdata: operation [2:0], page_number [16:3], zero padding above
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pfla_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // m_axis_tdata: status [2:0], result_page [14:3], header_dirty_out [15]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pfla_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfla_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pfla_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pfla_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pfla_pkg::*;

    logic    r_file_open;
    logic    r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_cmd    w_cmd;
    t_result w_res;
    logic    w_res_valid, w_res_ready, w_reg_sel;

    // Configuration register.
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_FILE_OPEN);
    assign prdata    = w_reg_sel ? {{(APB_DATA_W-1){1'b0}}, r_file_open} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_open <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_file_open <= pwdata[0];
        end
    end

    // Unpack the request beat.
    assign w_cmd.op   = t_op'(s_axis_tdata[2:0]);
    assign w_cmd.page = s_axis_tdata[PN_W+2:3];

    pfla_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_open (r_file_open),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register: loads whenever it is empty or being drained.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= {w_res.dirty, w_res.page, w_res.status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== verif/page_free_list_allocator_test.sv =====
// Self-checking testbench for the page free-list allocator: streams page requests,
// predicts every result beat with its own model of the free list and compares them.
// Depends on pfla_pkg and the page_free_list_allocator RTL.
module page_free_list_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;

    localparam logic [2:0]            OP_UNKNOWN       = 3'd7;
    localparam logic [APB_ADDR_W-1:0] ADDR_FILE_OPEN   = '0;
    localparam int                    RX_HOLD_CYCLES   = 300;
    localparam int                    WATCHDOG_LIMIT   = 20000;
    localparam int                    RANDOM_PER_PHASE = 430;
    localparam int                    REQ_AHEAD        = 4;

    typedef struct {
        logic [2:0]      op;
        logic [PN_W-1:0] pn;
    } t_page_req;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    // s_axis_tdata: operation [2:0], page_number [16:3], zero padding above
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    // m_axis_tdata: status [2:0], result_page [14:3], header_dirty_out [15]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Requests waiting for the driver and results still owed by the block.
    t_page_req page_reqs[$];
    t_result   due_results[$];

    int offered_beats  = 0;
    int accepted_beats = 0;
    int mismatches     = 0;
    int tx_idle_pct    = 27;
    int rx_idle_pct    = 61;
    int rx_hold_req    = 0;
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;
    int stall_cycles   = 0;

    // Shadow of the allocator state.
    logic [LINK_W-1:0] link_words [MAX_PAGES];
    logic [LINK_W-1:0] free_top      = LINK_END;
    logic [LINK_W-1:0] pages_in_file = '0;
    logic              hdr_dirty     = 1'b0;
    logic              file_is_open  = 1'b0;

    page_free_list_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit page_exists(int p);
        return p >= 0 && p < int'(pages_in_file);
    endfunction

    function automatic bit page_taken(int p);
        return page_exists(p) && link_words[p] == LINK_USED;
    endfunction

    // Nearest used page above start; start may be -1.
    function automatic t_status scan_up(int start, output logic [PAGE_W-1:0] hit);
        hit = '0;
        if (start != -1 && !page_exists(start))
            return ST_INVALID;
        for (int p = start + 1; p < int'(pages_in_file); p++) begin
            if (page_taken(p)) begin
                hit = PAGE_W'(p);
                return ST_OK;
            end
        end
        return ST_EOF;
    endfunction

    // Nearest used page below start; start may equal the page count.
    function automatic t_status scan_down(int start, output logic [PAGE_W-1:0] hit);
        hit = '0;
        if (start != int'(pages_in_file) && !page_exists(start))
            return ST_INVALID;
        for (int p = start - 1; p >= 0; p--) begin
            if (page_taken(p)) begin
                hit = PAGE_W'(p);
                return ST_OK;
            end
        end
        return ST_EOF;
    endfunction

    // Applies one request to the shadow state and returns the result beat it owes.
    function automatic t_result predict_page_op(logic [2:0] op, logic [PN_W-1:0] pn_bits);
        t_result           res;
        int                pn;
        int                slot;
        logic [PAGE_W-1:0] hit;
        pn = int'($signed(pn_bits));
        res.status = ST_OK;
        res.page = '0;
        hit = '0;
        if (!file_is_open) begin
            res.status = ST_CLOSED;
        end else begin
            case (op)
                OP_ALLOC: begin
                    if (free_top < MAX_PAGES) begin
                        // Reuse the most recently freed page.
                        slot = int'(free_top);
                        res.page = PAGE_W'(slot);
                        free_top = link_words[slot];
                        link_words[slot] = LINK_USED;
                        hdr_dirty = 1'b1;
                    end else if (pages_in_file < MAX_PAGES) begin
                        // Free list empty: extend the file.
                        slot = int'(pages_in_file);
                        res.page = PAGE_W'(slot);
                        link_words[slot] = LINK_USED;
                        pages_in_file = pages_in_file + 1'b1;
                        hdr_dirty = 1'b1;
                    end else begin
                        res.status = ST_NOSPACE;
                    end
                end
                OP_DISPOSE: begin
                    if (!page_exists(pn)) begin
                        res.status = ST_INVALID;
                    end else if (link_words[pn] != LINK_USED) begin
                        res.status = ST_FREE;
                    end else begin
                        link_words[pn] = free_top;
                        free_top = LINK_W'(pn);
                        hdr_dirty = 1'b1;
                    end
                end
                OP_GET_THIS: begin
                    if (page_taken(pn))
                        res.page = PAGE_W'(pn);
                    else
                        res.status = ST_INVALID;
                end
                OP_GET_NEXT: begin
                    res.status = scan_up(pn, hit);
                    res.page = hit;
                end
                OP_GET_PREV: begin
                    res.status = scan_down(pn, hit);
                    res.page = hit;
                end
                OP_GET_FRST: begin
                    res.status = scan_up(-1, hit);
                    res.page = hit;
                end
                OP_GET_LAST: begin
                    res.status = scan_down(int'(pages_in_file), hit);
                    res.page = hit;
                end
                default: begin
                    res.status = ST_INVALID;
                end
            endcase
        end
        if (res.status != ST_OK || op == OP_DISPOSE)
            res.page = '0;
        res.dirty = hdr_dirty;
        return res;
    endfunction

    function automatic logic [2:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return OP_ALLOC;
        if (roll < 45) return OP_DISPOSE;
        if (roll < 60) return OP_GET_THIS;
        if (roll < 72) return OP_GET_NEXT;
        if (roll < 84) return OP_GET_PREV;
        if (roll < 90) return OP_GET_FRST;
        if (roll < 97) return OP_GET_LAST;
        return OP_UNKNOWN;
    endfunction

    // Mostly pages of the file, some boundary starts and some raw noise.
    function automatic logic [PN_W-1:0] pick_page();
        int n;
        int roll;
        n = int'(pages_in_file);
        roll = $urandom_range(99);
        if (roll < 10)
            return PN_W'($urandom);
        if (roll < 20) begin
            roll = $urandom_range(3);
            if (roll == 0) return PN_W'(-1);
            if (roll == 1) return PN_W'(n);
            if (roll == 2) return PN_W'(n + 1);
            return PN_W'(-2);
        end
        if (n == 0)
            return '0;
        return PN_W'($urandom_range(n - 1));
    endfunction

    task automatic queue_req(logic [2:0] op, logic [PN_W-1:0] pn);
        t_page_req req;
        req.op = op;
        req.pn = pn;
        while (page_reqs.size() >= REQ_AHEAD)
            @(negedge i_clk);
        page_reqs.push_back(req);
    endtask

    task automatic run_random(int count);
        repeat (count) queue_req(pick_op(), pick_page());
    endtask

    // Returns once the sender is empty and every owed result has arrived.
    task automatic wait_all_results();
        do @(posedge i_clk);
        while (page_reqs.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes file_open, then reads it back.
    task automatic set_file_open(logic value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FILE_OPEN;
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        file_is_open = value;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value)) begin
            $display("%0t: file_open readback expected %0h, got %0h", $time, value, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Request driver: holds a beat until it is taken, then offers the next one.
    always @(negedge i_clk) begin
        t_page_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && accepted_beats != offered_beats)) begin
            if (page_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                req = page_reqs.pop_front();
                s_axis_tdata <= {{(IN_DATA_W - PN_W - 3){1'b0}}, req.pn, req.op};
                s_axis_tvalid <= 1'b1;
                offered_beats++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted request beat updates the shadow and owes one result.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            due_results.push_back(predict_page_op(s_axis_tdata[2:0], s_axis_tdata[16:3]));
            accepted_beats <= accepted_beats + 1;
        end
    end

    // Result receiver: random back-pressure plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: compares every result beat with the oldest owed result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %0h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_axis_tdata[2:0] !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_axis_tdata[2:0]);
                    mismatches++;
                end
                if (m_axis_tdata[14:3] !== want.page) begin
                    $display("%0t: result_page expected %0d, got %0d",
                             $time, want.page, m_axis_tdata[14:3]);
                    mismatches++;
                end
                if (m_axis_tdata[15] !== want.dirty) begin
                    $display("%0t: header_dirty_out expected %0d, got %0d",
                             $time, want.dirty, m_axis_tdata[15]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without a beat on either stream ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("page_free_list_allocator: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // File closed after reset: everything reports closed.
        queue_req(OP_ALLOC, '0);
        queue_req(OP_GET_FRST, '0);
        wait_all_results();
        set_file_open(1'b1);

        // Directed: empty file, growth, reuse, scans and bad pages.
        queue_req(OP_GET_FRST, '0);
        queue_req(OP_GET_PREV, '0);
        queue_req(OP_ALLOC, '0);
        queue_req(OP_ALLOC, PN_W'(-1));
        queue_req(OP_ALLOC, '0);
        queue_req(OP_GET_THIS, '0);
        queue_req(OP_GET_THIS, PN_W'(-1));
        queue_req(OP_GET_THIS, PN_W'(3));
        queue_req(OP_DISPOSE, PN_W'(1));
        queue_req(OP_DISPOSE, PN_W'(1));
        queue_req(OP_GET_THIS, PN_W'(1));
        queue_req(OP_GET_NEXT, PN_W'(-1));
        queue_req(OP_GET_NEXT, '0);
        queue_req(OP_GET_NEXT, PN_W'(2));
        queue_req(OP_GET_NEXT, PN_W'(-2));
        queue_req(OP_GET_PREV, PN_W'(3));
        queue_req(OP_GET_PREV, PN_W'(2));
        queue_req(OP_GET_PREV, PN_W'(4));
        queue_req(OP_GET_LAST, '0);
        queue_req(OP_UNKNOWN, '0);
        queue_req(OP_DISPOSE, PN_W'(8191));
        queue_req(OP_GET_THIS, PN_W'(-8192));
        queue_req(OP_ALLOC, '0);
        queue_req(OP_GET_PREV, '0);
        wait_all_results();

        // Random, busy sender and slow receiver; sender pauses halfway.
        run_random(200);
        wait_all_results();
        run_random(RANDOM_PER_PHASE - 200);
        wait_all_results();

        // Short stretch with the file closed.
        set_file_open(1'b0);
        run_random(20);
        wait_all_results();
        set_file_open(1'b1);

        // Random, slow sender and busy receiver.
        tx_idle_pct = 61;
        rx_idle_pct = 27;
        run_random(RANDOM_PER_PHASE);
        wait_all_results();

        // Random at full rate, with one long receiver hold-off to back up the input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(150);
        rx_hold_req++;
        run_random(RANDOM_PER_PHASE - 150);
        wait_all_results();

        // Directed around the store limits.
        queue_req(OP_GET_FRST, '0);
        queue_req(OP_GET_LAST, '0);
        queue_req(OP_GET_NEXT, PN_W'(-1));
        queue_req(OP_GET_PREV, PN_W'(MAX_PAGES));
        queue_req(OP_DISPOSE, PN_W'(MAX_PAGES - 1));
        queue_req(OP_DISPOSE, '0);
        queue_req(OP_DISPOSE, '0);
        queue_req(OP_GET_FRST, '0);
        queue_req(OP_GET_LAST, '0);
        queue_req(OP_GET_NEXT, PN_W'(MAX_PAGES - 2));
        queue_req(OP_GET_PREV, PN_W'(1));
        queue_req(OP_ALLOC, '0);
        queue_req(OP_ALLOC, '0);
        queue_req(OP_ALLOC, '0);
        queue_req(OP_GET_NEXT, PN_W'(MAX_PAGES - 1));
        queue_req(OP_GET_PREV, PN_W'(MAX_PAGES));
        queue_req(OP_GET_THIS, PN_W'(MAX_PAGES));
        wait_all_results();

        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("page_free_list_allocator: match");
        end else begin
            $display("page_free_list_allocator: mismatch");
        end
        $finish;
    end

endmodule
